/* hdl/rti_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rti_pkg
// Shared constants for the ray/triangle intersection core: register
// indexes, result field widths and saturation values.
// ----------------------------------------------------------------------------
package rti_pkg;

    typedef enum logic [1:0] {
        REG_VERTEX_A      = 2'd0,
        REG_VERTEX_B      = 2'd1,
        REG_VERTEX_C      = 2'd2,
        REG_DET_THRESHOLD = 2'd3
    } cfg_reg_t;

    localparam int CFG_W      = 48;
    localparam int THR_W      = 32;
    localparam logic [THR_W-1:0] THR_RESET = 32'd1677;

    localparam int DIST_W     = 32;
    localparam int BARY_W     = 16;
    localparam int OUT_W      = DIST_W + 2 * BARY_W;

    // one quotient bit per divider stage
    localparam int DIV_STEPS  = 32;

    localparam logic [DIST_W-1:0] DIST_MAX = 32'h7fff_ffff;
    localparam logic [DIST_W-1:0] DIST_MIN = 32'h8000_0000;

endpackage : rti_pkg
`default_nettype wire

/* hdl/ray_triangle_intersect_core.sv */
// Each ray passes stages 1..6, setup stage 7, the dividers and the output register.
// Throughput: one ray per cycle; a new ray can enter every cycle while the skid stage is empty.
// The dividers are 32 one-bit-per-stage restoring divider stages.
// A skid stage lets one more ray enter while a result waits on m_tready.
// Reset (rst_n low, asynchronous): pipeline empty, vertices 0, threshold 1677.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ray_triangle_intersect_core
// Pipelined Moller-Trumbore ray/triangle test. Edges come from the vertex
// registers; each ray yields a hit flag, distance t and barycentrics u, v.
// ----------------------------------------------------------------------------
module ray_triangle_intersect_core #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // configuration write port
    input  wire logic                                cfg_we,
    input  wire logic [1:0]                          cfg_index,
    input  wire logic [rti_pkg::CFG_W-1:0]           cfg_data,
    // ray stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (low bits first)
    input  wire logic [((6*COORD_WIDTH+7)/8)*8-1:0]  s_tdata,
    // result stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // distance, bary_u, bary_v (low bits first)
    output logic [rti_pkg::OUT_W-1:0]                m_tdata,
    // hit
    output logic [0:0]                               m_tuser
);

    localparam int CW  = COORD_WIDTH;
    localparam int EW  = CW + 1;          // edges and origin offset
    localparam int PMW = 2 * CW + 1;      // d * e2 products
    localparam int QMW = 2 * CW + 2;      // s * e1 products
    localparam int PW  = 2 * CW + 2;      // P = d x e2
    localparam int QW  = 2 * CW + 3;      // Q = s x e1
    localparam int NW  = 3 * CW + 6;      // dot products and sums
    localparam int VXW = (3 * CW > rti_pkg::CFG_W) ? 3 * CW : rti_pkg::CFG_W;
    localparam int CMPW = (NW + 1 > rti_pkg::THR_W + 1) ? NW + 1 : rti_pkg::THR_W + 1;
    localparam int NS  = rti_pkg::DIV_STEPS;

    typedef struct packed {
        logic [NW-1:0] den;
        logic [NW-1:0] rem_u;
        logic [NW-1:0] rem_v;
        logic [NW-1:0] rem_t;
        logic [31:0]   nlo_u;
        logic [31:0]   nlo_v;
        logic [31:0]   nlo_t;
        logic [31:0]   q_u;
        logic [31:0]   q_v;
        logic [31:0]   q_t;
        logic          miss;
        logic          tneg;
        logic          tovf;
    } div_t;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [rti_pkg::CFG_W-1:0] vertex_a_reg, vertex_b_reg, vertex_c_reg;
    logic [rti_pkg::THR_W-1:0] thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_a_reg <= '0;
            vertex_b_reg <= '0;
            vertex_c_reg <= '0;
            thr_reg      <= rti_pkg::THR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (rti_pkg::cfg_reg_t'(cfg_index))
                rti_pkg::REG_VERTEX_A:      vertex_a_reg <= cfg_data;
                rti_pkg::REG_VERTEX_B:      vertex_b_reg <= cfg_data;
                rti_pkg::REG_VERTEX_C:      vertex_c_reg <= cfg_data;
                rti_pkg::REG_DET_THRESHOLD: thr_reg <= cfg_data[rti_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    // Vertex bits above the 48-bit register read as zero for wide coordinates.
    logic [VXW-1:0] va_wide, vb_wide, vc_wide;
    assign va_wide = VXW'(vertex_a_reg);
    assign vb_wide = VXW'(vertex_b_reg);
    assign vc_wide = VXW'(vertex_c_reg);

    // Edges are static between configuration writes, so plain logic here.
    logic signed [CW-1:0] va [3];
    logic signed [EW-1:0] e1 [3];
    logic signed [EW-1:0] e2 [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            va[i] = signed'(va_wide[i*CW +: CW]);
            e1[i] = EW'(signed'(vb_wide[i*CW +: CW])) - EW'(va[i]);
            e2[i] = EW'(signed'(vc_wide[i*CW +: CW])) - EW'(va[i]);
        end
    end

    // ------------------------------------------------------------------
    // flow control: one global advance, skid stage at the output
    // ------------------------------------------------------------------
    logic adv;
    logic skid_valid_reg, out_valid_reg;
    assign adv      = !skid_valid_reg;
    assign s_tready = adv;

    // valid bits of stages 1..6; stage 7 is div_valid_reg[0]
    logic [6:1]  v_reg;
    logic [NS:0] div_valid_reg;

    // ------------------------------------------------------------------
    // stages 1..6: offsets, cross products, dot products, sign fix
    // ------------------------------------------------------------------
    logic signed [CW-1:0]  d1_reg [3], d2_reg [3], d3_reg [3];
    logic signed [EW-1:0]  s1_reg [3], s2_reg [3], s3_reg [3];
    logic signed [PMW-1:0] pm_reg [6];
    logic signed [QMW-1:0] qm_reg [6];
    logic signed [PW-1:0]  p_reg [3];
    logic signed [QW-1:0]  q_reg [3];
    logic signed [NW-1:0]  m_det_reg [3], m_nu_reg [3], m_nv_reg [3], m_nt_reg [3];
    logic signed [NW-1:0]  det5_reg, nu5_reg, nv5_reg, nt5_reg;
    logic signed [NW-1:0]  det6_reg, nu6_reg, nv6_reg, nt6_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                d1_reg[i] <= signed'(s_tdata[(3+i)*CW +: CW]);
                s1_reg[i] <= EW'(signed'(s_tdata[i*CW +: CW])) - EW'(va[i]);
            end
            for (int i = 0; i < 3; i++)
            begin
                pm_reg[2*i]   <= d1_reg[(i+1)%3] * e2[(i+2)%3];
                pm_reg[2*i+1] <= d1_reg[(i+2)%3] * e2[(i+1)%3];
                qm_reg[2*i]   <= s1_reg[(i+1)%3] * e1[(i+2)%3];
                qm_reg[2*i+1] <= s1_reg[(i+2)%3] * e1[(i+1)%3];
                d2_reg[i]     <= d1_reg[i];
                s2_reg[i]     <= s1_reg[i];
            end
            for (int i = 0; i < 3; i++)
            begin
                p_reg[i]  <= PW'(pm_reg[2*i]) - PW'(pm_reg[2*i+1]);
                q_reg[i]  <= QW'(qm_reg[2*i]) - QW'(qm_reg[2*i+1]);
                d3_reg[i] <= d2_reg[i];
                s3_reg[i] <= s2_reg[i];
            end
            for (int i = 0; i < 3; i++)
            begin
                m_det_reg[i] <= NW'(e1[i]) * NW'(p_reg[i]);
                m_nu_reg[i]  <= NW'(s3_reg[i]) * NW'(p_reg[i]);
                m_nv_reg[i]  <= NW'(d3_reg[i]) * NW'(q_reg[i]);
                m_nt_reg[i]  <= NW'(e2[i]) * NW'(q_reg[i]);
            end
            det5_reg <= m_det_reg[0] + m_det_reg[1] + m_det_reg[2];
            nu5_reg  <= m_nu_reg[0] + m_nu_reg[1] + m_nu_reg[2];
            nv5_reg  <= m_nv_reg[0] + m_nv_reg[1] + m_nv_reg[2];
            nt5_reg  <= m_nt_reg[0] + m_nt_reg[1] + m_nt_reg[2];
            // make the determinant nonnegative
            if (det5_reg < 0)
            begin
                det6_reg <= -det5_reg;
                nu6_reg  <= -nu5_reg;
                nv6_reg  <= -nv5_reg;
                nt6_reg  <= -nt5_reg;
            end
            else
            begin
                det6_reg <= det5_reg;
                nu6_reg  <= nu5_reg;
                nv6_reg  <= nv5_reg;
                nt6_reg  <= nt5_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 7: hit tests, t overflow check, divider setup
    // ------------------------------------------------------------------
    logic signed [NW:0]      uv_sum;
    logic [NW-1:0]           det_u, nt_abs;
    logic [NW+14:0]          num_u, num_v;
    logic [NW+15:0]          num_t;
    div_t                    div_init;

    always_comb
    begin
        uv_sum = (NW+1)'(nu6_reg) + (NW+1)'(nv6_reg);
        det_u  = $unsigned(det6_reg);
        nt_abs = nt6_reg[NW-1] ? $unsigned(-nt6_reg) : $unsigned(nt6_reg);
        num_u  = {$unsigned(nu6_reg), 15'b0};
        num_v  = {$unsigned(nv6_reg), 15'b0};
        num_t  = {nt_abs, 16'b0};

        div_init.den   = det_u;
        div_init.miss  = (det6_reg == 0)
                      || (CMPW'(det_u) < CMPW'(thr_reg))
                      || (nu6_reg < 0) || (nu6_reg > det6_reg)
                      || (nv6_reg < 0) || (uv_sum > (NW+1)'(det6_reg));
        div_init.tneg  = nt6_reg[NW-1];
        // quotient would need more than 32 bits
        div_init.tovf  = (NW+16)'(nt_abs) >= {det_u, 16'b0};
        div_init.rem_u = NW'(num_u >> 32);
        div_init.rem_v = NW'(num_v >> 32);
        div_init.rem_t = NW'(num_t >> 32);
        div_init.nlo_u = num_u[31:0];
        div_init.nlo_v = num_v[31:0];
        div_init.nlo_t = num_t[31:0];
        div_init.q_u   = '0;
        div_init.q_v   = '0;
        div_init.q_t   = '0;
    end

    // ------------------------------------------------------------------
    // restoring dividers, one quotient bit per stage
    // ------------------------------------------------------------------
    function automatic div_t div_step(input div_t x);
        div_t          y;
        logic [NW-1:0] tu;
        logic [NW-1:0] tv;
        logic [NW-1:0] tt;
        y  = x;
        tu = {x.rem_u[NW-2:0], x.nlo_u[31]};
        tv = {x.rem_v[NW-2:0], x.nlo_v[31]};
        tt = {x.rem_t[NW-2:0], x.nlo_t[31]};
        y.rem_u = (tu >= x.den) ? tu - x.den : tu;
        y.rem_v = (tv >= x.den) ? tv - x.den : tv;
        y.rem_t = (tt >= x.den) ? tt - x.den : tt;
        y.q_u   = {x.q_u[30:0], tu >= x.den};
        y.q_v   = {x.q_v[30:0], tv >= x.den};
        y.q_t   = {x.q_t[30:0], tt >= x.den};
        y.nlo_u = {x.nlo_u[30:0], 1'b0};
        y.nlo_v = {x.nlo_v[30:0], 1'b0};
        y.nlo_t = {x.nlo_t[30:0], 1'b0};
        return y;
    endfunction

    div_t div_reg [NS+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            div_reg[0] <= div_init;
            for (int k = 1; k <= NS; k++)
            begin
                div_reg[k] <= div_step(div_reg[k-1]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            div_valid_reg <= '0;
        end
        else if (adv)
        begin
            v_reg         <= {v_reg[5:1], s_tvalid};
            div_valid_reg <= {div_valid_reg[NS-1:0], v_reg[6]};
        end
    end

    // ------------------------------------------------------------------
    // result formatting: saturate t, zero everything on a miss
    // ------------------------------------------------------------------
    div_t                        fin;
    logic [rti_pkg::DIST_W-1:0]  t_sat;
    logic [rti_pkg::OUT_W-1:0]   res_data;
    logic                        res_hit;

    always_comb
    begin
        fin = div_reg[NS];
        if (fin.tneg)
        begin
            t_sat = (fin.tovf || fin.q_t > rti_pkg::DIST_MIN) ? rti_pkg::DIST_MIN
                                                              : 32'd0 - fin.q_t;
        end
        else
        begin
            t_sat = (fin.tovf || fin.q_t[31]) ? rti_pkg::DIST_MAX : fin.q_t;
        end
        res_hit  = !fin.miss;
        res_data = fin.miss ? '0
                            : {fin.q_v[rti_pkg::BARY_W-1:0], fin.q_u[rti_pkg::BARY_W-1:0],
                               t_sat};
    end

    // ------------------------------------------------------------------
    // output register plus one skid entry
    // ------------------------------------------------------------------
    logic [rti_pkg::OUT_W-1:0] out_data_reg, skid_data_reg;
    logic                      out_hit_reg, skid_hit_reg;
    logic                      pipe_valid;
    assign pipe_valid = adv && div_valid_reg[NS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (m_tready || !out_valid_reg)
        begin
            out_valid_reg  <= skid_valid_reg || pipe_valid;
            skid_valid_reg <= 1'b0;
        end
        else if (pipe_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_tready || !out_valid_reg)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : res_data;
            out_hit_reg  <= skid_valid_reg ? skid_hit_reg : res_hit;
        end
        else if (pipe_valid)
        begin
            skid_data_reg <= res_data;
            skid_hit_reg  <= res_hit;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_hit_reg;

`ifndef SYNTH
    // a parked result implies the output register is occupied
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a word while the output register is empty");

    // a miss reports zeros in every field
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("miss with nonzero result fields");

    // barycentrics of a hit never exceed one
    a_bary_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |->
        (m_tdata[47:32] <= 16'h8000 && m_tdata[63:48] <= 16'h8000))
        else $error("barycentric out of range");

    // no word enters the pipeline while the skid entry is full
    a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |=> ($stable(div_valid_reg) || !skid_valid_reg || !$past(skid_valid_reg)))
        else $error("pipeline moved while stalled");
`endif

endmodule : ray_triangle_intersect_core
`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for ray_triangle_intersect_core. Rays go in on the
// slave stream, each is scored by an exact-integer ray/triangle model or by a typed result, and
// every result word is compared field by field in arrival order. Runs over
// several triangles and thresholds, with random gaps and back-pressure.
// ----------------------------------------------------------------------------
module testbench;

    // ray word, origin_x in the low bits
    typedef struct packed {
        logic signed [15:0] dz, dy, dx, oz, oy, ox;
    } ray_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] distance;
        logic [15:0] u, v;
    } hit_t;

    typedef struct {
        ray_t ray;
        bit   typed;
        hit_t res;
    } row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [1:0]                cfg_index;
    logic [rti_pkg::CFG_W-1:0] cfg_data;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [95:0]               s_tdata;
    logic                      m_tvalid;
    logic                      m_tready;
    logic [rti_pkg::OUT_W-1:0] m_tdata;
    logic [0:0]                m_tuser;

    // shadow of the register file
    logic [47:0] vert [3];
    logic [31:0] thr;

    hit_t pending_hits [$];
    row_t rows [$];
    int   errors;
    bit   no_idle;

    ray_triangle_intersect_core dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    // exact Moller-Trumbore score of one ray against the shadow triangle
    function automatic hit_t intersect_ray(ray_t r);
        logic signed [127:0] a [3], e1 [3], e2 [3], d [3], s [3], p [3], q [3];
        logic signed [127:0] det, nu, nv, nt, tq;
        logic signed [15:0]  o [3], dd [3];
        hit_t h;
        o  = '{r.ox, r.oy, r.oz};
        dd = '{r.dx, r.dy, r.dz};
        for (int i = 0; i < 3; i++)
        begin
            a[i]  = signed'(vert[0][16*i +: 16]);
            e1[i] = signed'(vert[1][16*i +: 16]) - a[i];
            e2[i] = signed'(vert[2][16*i +: 16]) - a[i];
            s[i]  = o[i] - a[i];
            d[i]  = dd[i];
        end
        p[0] = d[1]*e2[2] - d[2]*e2[1];
        p[1] = d[2]*e2[0] - d[0]*e2[2];
        p[2] = d[0]*e2[1] - d[1]*e2[0];
        q[0] = s[1]*e1[2] - s[2]*e1[1];
        q[1] = s[2]*e1[0] - s[0]*e1[2];
        q[2] = s[0]*e1[1] - s[1]*e1[0];
        det = e1[0]*p[0] + e1[1]*p[1] + e1[2]*p[2];
        nu  = s[0]*p[0] + s[1]*p[1] + s[2]*p[2];
        nv  = d[0]*q[0] + d[1]*q[1] + d[2]*q[2];
        nt  = e2[0]*q[0] + e2[1]*q[1] + e2[2]*q[2];
        h = '0;
        if (det < 0)
        begin
            det = -det; nu = -nu; nv = -nv; nt = -nt;
        end
        if (det == 0 || det < $signed({96'd0, thr})) return h;
        if (nu < 0 || nu > det) return h;
        if (nv < 0 || nu + nv > det) return h;
        h.hit = 1'b1;
        h.u = 16'((nu <<< 15) / det);
        h.v = 16'((nv <<< 15) / det);
        if (nt < 0)
        begin
            tq = ((-nt) <<< 16) / det;
            h.distance = (tq > 128'sh8000_0000) ? rti_pkg::DIST_MIN : 32'(-tq);
        end
        else
        begin
            tq = (nt <<< 16) / det;
            h.distance = (tq > 128'sh7fff_ffff) ? rti_pkg::DIST_MAX : 32'(tq);
        end
        return h;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side: random back-pressure, changes on the falling edge
    initial
    begin
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                m_tready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready = 1'b1;
        end
    end

    // scoreboard: compare each result word with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            hit_t want;
            hit_t got;
            got = {m_tuser[0], m_tdata[31:0], m_tdata[47:32], m_tdata[63:48]};
            if (pending_hits.size() == 0)
            begin
                $display("%0t: unexpected result word %h", $time, got);
                errors++;
            end
            else
            begin
                want = pending_hits.pop_front();
                if (got.hit !== want.hit)
                begin
                    $display("%0t: hit exp %b got %b", $time, want.hit, got.hit);
                    errors++;
                end
                if (got.distance !== want.distance)
                begin
                    $display("%0t: distance exp %h got %h", $time, want.distance,
                             got.distance);
                    errors++;
                end
                if (got.u !== want.u)
                begin
                    $display("%0t: bary_u exp %h got %h", $time, want.u, got.u);
                    errors++;
                end
                if (got.v !== want.v)
                begin
                    $display("%0t: bary_v exp %h got %h", $time, want.v, got.v);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(rti_pkg::cfg_reg_t idx, logic [47:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        if (idx == rti_pkg::REG_DET_THRESHOLD) thr = val[31:0];
        else vert[idx] = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // drain the pipe before touching the registers
    task automatic settle();
        wait (pending_hits.size() == 0);
        repeat (60) @(posedge clk);
    endtask

    // present one ray word and hold it until taken; leaves s_tvalid high
    task automatic send_ray(ray_t r, bit typed, hit_t res);
        int   gap;
        hit_t want;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = r;
        forever
        begin
            @(posedge clk);
            if (s_tready) break;
        end
        want = typed ? res : intersect_ray(r);
        pending_hits = {pending_hits, want};
        @(negedge clk);
    endtask

    function automatic ray_t mk_ray(int ox, int oy, int oz, int dx, int dy, int dz);
        ray_t r;
        r = {16'(dz), 16'(dy), 16'(dx), 16'(oz), 16'(oy), 16'(ox)};
        return r;
    endfunction

    function automatic logic [47:0] mk_vert(int x, int y, int z);
        return {16'(z), 16'(y), 16'(x)};
    endfunction

    task automatic add_row(ray_t r, bit typed, hit_t res);
        row_t w;
        w.ray = r; w.typed = typed; w.res = res;
        rows = {rows, w};
    endtask

    function automatic int coord_of(int k, int i);
        return int'(signed'(vert[k][16*i +: 16]));
    endfunction

    // ray aimed at a random point of the current triangle, or plain noise
    function automatic ray_t random_ray(bit aimed);
        int u8, v8, tgt [3], org [3], dir [3];
        int sc;
        if (!aimed) return ray_t'({$urandom, $urandom, $urandom});
        u8 = $urandom_range(0, 256);
        v8 = $urandom_range(0, 256 - u8);
        sc = $urandom_range(1, 2);
        for (int i = 0; i < 3; i++)
        begin
            tgt[i] = coord_of(0, i) + (u8 * (coord_of(1, i) - coord_of(0, i))
                     + v8 * (coord_of(2, i) - coord_of(0, i))) / 256;
            org[i] = $urandom_range(0, 8192) - 4096;
            dir[i] = (tgt[i] - org[i]) / sc;
            if ($urandom_range(0, 7) == 0) dir[i] = -dir[i];
        end
        return mk_ray(org[0], org[1], org[2], dir[0], dir[1], dir[2]);
    endfunction

    function automatic logic [47:0] random_vert(int span);
        return mk_vert($urandom_range(0, 2*span) - span,
                       $urandom_range(0, 2*span) - span,
                       $urandom_range(0, 2*span) - span);
    endfunction

    initial
    begin
        hit_t none;
        hit_t hres;
        none      = '0;
        errors    = 0;
        no_idle   = 1'b0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = rti_pkg::REG_VERTEX_A;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        vert      = '{48'd0, 48'd0, 48'd0};
        thr       = rti_pkg::THR_RESET;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // degenerate triangle out of reset: everything misses
        send_ray(mk_ray(64, 64, 256, 0, 0, -256), 1'b1, none);
        send_ray(ray_t'({$urandom, $urandom, $urandom}), 1'b1, none);
        s_tvalid = 1'b0;
        settle();

        // right triangle with legs of 256 in the z=0 plane, default threshold
        write_reg(rti_pkg::REG_VERTEX_A, mk_vert(0, 0, 0));
        write_reg(rti_pkg::REG_VERTEX_B, mk_vert(256, 0, 0));
        write_reg(rti_pkg::REG_VERTEX_C, mk_vert(0, 256, 0));

        hres = '{1'b1, 32'h0001_0000, 16'd8192, 16'd8192};
        add_row(mk_ray(64, 64, 256, 0, 0, -256), 1'b1, hres);     // straight hit
        add_row(mk_ray(64, 64, 256, 256, 0, 0), 1'b1, none);      // parallel, det zero
        add_row(mk_ray(-64, 64, 256, 0, 0, -256), 1'b1, none);    // u below zero
        add_row(mk_ray(64, -64, 256, 0, 0, -256), 1'b1, none);    // v below zero
        add_row(mk_ray(192, 192, 256, 0, 0, -256), 1'b1, none);   // u+v past one
        hres = '{1'b1, 32'hffff_0000, 16'd8192, 16'd8192};
        add_row(mk_ray(64, 64, -256, 0, 0, -256), 1'b1, hres);    // behind origin
        hres = '{1'b1, 32'h0001_0000, 16'd32768, 16'd0};
        add_row(mk_ray(256, 0, 256, 0, 0, -256), 1'b1, hres);     // u exactly one
        add_row(mk_ray(0, 256, 256, 0, 0, -256), 1'b0, none);     // v exactly one
        add_row(mk_ray(32767, 32767, 32767, -32768, -32768, -32768), 1'b0, none);
        add_row(mk_ray(-32768, -32768, -32768, 32767, 32767, 32767), 1'b0, none);
        add_row(mk_ray(64, 64, 32767, 0, 0, -1), 1'b0, none);     // far, tiny dir
        add_row(mk_ray(64, 64, -32768, 0, 0, 1), 1'b0, none);
        add_row(mk_ray(1, 1, 1, 0, 0, -1), 1'b0, none);           // hit close to vertex A
        foreach (rows[i]) send_ray(rows[i].ray, rows[i].typed, rows[i].res);
        s_tvalid = 1'b0;
        settle();

        // random phases: triangle and threshold change between them
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(rti_pkg::REG_DET_THRESHOLD, 48'd0);
                end
                1:
                begin
                    // full-scale corners, largest threshold
                    write_reg(rti_pkg::REG_VERTEX_A, mk_vert(-32768, -32768, 32767));
                    write_reg(rti_pkg::REG_VERTEX_B, mk_vert(32767, -32768, -32768));
                    write_reg(rti_pkg::REG_VERTEX_C, mk_vert(-32768, 32767, -32768));
                    write_reg(rti_pkg::REG_DET_THRESHOLD, 48'hffff_ffff);
                end
                2:
                begin
                    write_reg(rti_pkg::REG_VERTEX_A, {$urandom, $urandom});
                    write_reg(rti_pkg::REG_VERTEX_B, {$urandom, $urandom});
                    write_reg(rti_pkg::REG_VERTEX_C, {$urandom, $urandom});
                    write_reg(rti_pkg::REG_DET_THRESHOLD, 48'(rti_pkg::THR_RESET));
                end
                default:
                begin
                    write_reg(rti_pkg::REG_VERTEX_A, random_vert(2048));
                    write_reg(rti_pkg::REG_VERTEX_B, random_vert(2048));
                    write_reg(rti_pkg::REG_VERTEX_C, random_vert(2048));
                    write_reg(rti_pkg::REG_DET_THRESHOLD, 48'($urandom_range(0, 1 << 20)));
                end
            endcase
            no_idle = (ph == 4);
            for (int n = 0; n < 125; n++)
                send_ray(random_ray($urandom_range(0, 9) < 7), 1'b0, none);
            s_tvalid = 1'b0;
            settle();
        end

        if (errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
